// ===== sv/sai_pkg.sv =====
// shared constants, types and codes of the sorted array insert/delete block
`default_nettype none

package sai_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W  = 6;
  localparam int VAL_W    = 31;
  localparam int STATUS_W = 2;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // one queued command between the front and the back
  typedef struct packed {
    op_t  op;
    val_t value;
  } cmd_t;

  // queue head seen by the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

`default_nettype wire

// ===== sv/sai_if.sv =====
// valid/ready channel interfaces for the input and result words
`default_nettype none

interface sai_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [sai_pkg::VAL_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sai_out_if;
  logic                        valid;
  logic                        ready;
  logic [sai_pkg::STATUS_W-1:0] status;
  logic [sai_pkg::COUNT_W-1:0]  count;
  logic [sai_pkg::VAL_W-1:0]    element;
  logic                        element_valid;
  logic                        last;

  modport source (output valid, output status, output count, output element,
                  output element_valid, output last, input ready);
  modport sink   (input valid, input status, input count, input element,
                  input element_valid, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/sorted_array_insert_delete_core.sv =====
// sorted list insert/delete: each operation is applied in parallel across the shifting cell row,
// then the list is read out one word per cycle unless out_if.ready stalls it, one word per held
// entry or a single word when the list is empty, each word leaving through the registered output word.
// a two-entry command queue lets new operations be taken while a readout runs.
// reset (synchronous, active low) empties the list and queue; list cells are not cleared.
`default_nettype none

module sorted_array_insert_delete_core (
  input  wire logic clk,
  input  wire logic rst_n,
  sai_in_if.sink    in_if,
  sai_out_if.source out_if
);
  import sai_pkg::*;

  head_t head;
  logic  head_pop;

  sai_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .head     (head),
    .head_pop (head_pop)
  );

  sai_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_pop (head_pop),
    .out_if   (out_if)
  );

endmodule

`default_nettype wire

// ===== sv/sai_front.sv =====
// input acceptance, operation decode and a short command queue
`default_nettype none

module sai_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sai_in_if.sink             in_if,
  output sai_pkg::head_t     head,
  input  wire logic          head_pop
);
  import sai_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;
  logic              push, pop;
  cmd_t              in_cmd;

  assign in_if.ready = (fill_r != QCNT_W'(QDEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign pop         = head_pop && (fill_r != '0);

  always_comb begin
    in_cmd.op    = in_if.kind ? OP_DELETE : OP_INSERT;
    in_cmd.value = in_if.value;
  end

  assign head.valid = (fill_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QCNT_W'(QDEPTH))
    else $error("command queue overfilled");

endmodule

`default_nettype wire

// ===== sv/sai_back.sv =====
// list storage with parallel shift on insert/delete, and the list readout
`default_nettype none

module sai_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sai_pkg::head_t head,
  output logic               head_pop,
  sai_out_if.source          out_if
);
  import sai_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t  state_r;
  val_t    ent_r [CAPACITY];
  val_t    ent_nxt [CAPACITY];
  count_t  cnt_r, cnt_nxt;
  status_t st_r, st_nxt;
  idx_t    k_r;

  logic    ov_r;
  status_t o_status_r;
  count_t  o_count_r;
  val_t    o_elem_r;
  logic    o_ev_r;
  logic    o_last_r;

  logic [CAPACITY-1:0] valid_e, le, lt, eq;
  logic    found, full, ld_out, is_last;
  val_t    v;

  assign v        = head.cmd.value;
  assign head_pop = (state_r == S_IDLE);
  assign full     = (cnt_r >= COUNT_W'(CAPACITY));
  assign found    = |eq;

  // per-cell compare against the command value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_e[i] = COUNT_W'(i) < cnt_r;
      le[i]      = valid_e[i] && (ent_r[i] <= v);
      lt[i]      = valid_e[i] && (ent_r[i] < v);
      eq[i]      = valid_e[i] && (ent_r[i] == v);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    cnt_nxt = cnt_r;
    st_nxt  = ST_DONE;
    if (head.cmd.op == OP_INSERT) begin
      if (full) begin
        st_nxt = ST_FULL;
      end else begin
        cnt_nxt    = cnt_r + 1'b1;
        // cells above the insertion point move up by one
        ent_nxt[0] = le[0] ? ent_r[0] : v;
        for (int i = 1; i < CAPACITY; i++) begin
          if (le[i]) begin
            ent_nxt[i] = ent_r[i];
          end else if (le[i-1]) begin
            ent_nxt[i] = v;
          end else begin
            ent_nxt[i] = ent_r[i-1];
          end
        end
      end
    end else begin
      if (!found) begin
        st_nxt = ST_MISSING;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        // first equal entry is the first one not below v
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (!lt[i]) begin
            ent_nxt[i] = ent_r[i+1];
          end
        end
      end
    end
  end

  assign ld_out  = (state_r == S_EMIT) && (!ov_r || out_if.ready);
  assign is_last = (cnt_r == '0) || ((COUNT_W'(k_r) + COUNT_W'(1)) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      st_r     <= ST_DONE;
      k_r      <= '0;
      ov_r     <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            cnt_r   <= cnt_nxt;
            st_r    <= st_nxt;
            k_r     <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (ld_out) begin
            k_r <= k_r + 1'b1;
            if (is_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (ld_out) begin
        ov_r <= 1'b1;
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // list cells and output word carry no reset
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && head.valid) begin
      for (int i = 0; i < CAPACITY; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
    end
    if (ld_out) begin
      o_status_r <= st_r;
      o_count_r  <= cnt_r;
      o_elem_r   <= (cnt_r == '0) ? '0 : ent_r[k_r];
      o_ev_r     <= (cnt_r != '0);
      o_last_r   <= is_last;
    end
  end

  assign out_if.valid         = ov_r;
  assign out_if.status        = o_status_r;
  assign out_if.count         = o_count_r;
  assign out_if.element       = o_elem_r;
  assign out_if.element_valid = o_ev_r;
  assign out_if.last          = o_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !o_ev_r |-> o_last_r && (o_count_r == '0))
    else $error("empty-list word not flagged last");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && (cnt_r != '0) |-> COUNT_W'(k_r) < cnt_r)
    else $error("readout index past held count");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && head.valid && (st_nxt != ST_DONE) |=> $stable(cnt_r))
    else $error("refused operation changed the count");

endmodule

`default_nettype wire
